/* rtl/core/fbre_pkg.sv */
// ----------------------------------------------------------------------------
// fbre_pkg
// shared widths and constants of the four band ratio/error core
// ----------------------------------------------------------------------------
`default_nettype none
package fbre_pkg;
  localparam int unsigned PixelW   = 20;
  localparam int unsigned PixelBits = 20;
  localparam int unsigned SumW     = 36;
  localparam int unsigned CountW   = 17;
  localparam int unsigned OutW     = 48;
  localparam int unsigned QtyW     = 4;
  localparam int unsigned MaxPoints = 65536;
  localparam logic [CountW-1:0] PointCap =
    (MaxPoints < 131071) ? CountW'(MaxPoints) : CountW'(131071);
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [OutW-1:0] OutMax = {OutW{1'b1}};
  localparam logic [OutW-1:0] ErrFlag = OutW'(64'd100000 << 16);
  // quantity codes
  localparam logic [QtyW-1:0] QtyFull    = 4'd0;
  localparam logic [QtyW-1:0] QtyRatioAb = 4'd1;
  localparam logic [QtyW-1:0] QtyRatioBc = 4'd2;
  localparam logic [QtyW-1:0] QtyRatioCd = 4'd3;
  localparam logic [QtyW-1:0] QtyRatioDa = 4'd4;
  localparam logic [QtyW-1:0] QtyMeanA   = 4'd5;
  localparam logic [QtyW-1:0] QtyMeanD   = 4'd8;
endpackage
`default_nettype wire

/* rtl/core/four_band_ratio_error_core.sv */
// ----------------------------------------------------------------------------
// four_band_ratio_error_core
// per-bin four band sums with a selected ratio or mean and its poisson error
// ----------------------------------------------------------------------------
// Points stream in one per cycle and are added into four saturating 36-bit
// sums while the core is accumulating. On the point marked tlast the core
// stops taking points and runs its arithmetic bit-serially: each reciprocal
// 2^56/S is a restoring division loaded in ST_SETR, one quotient bit a cycle
// (up to four of them), the value is one 65-bit restoring division, also
// loaded in ST_SETR, and the error is a square root, one result bit a cycle.
// All divisions share one divider. The result is held in an output register
// until taken; the next bin starts once the result has left.
// Empty band: any zero sum forces the error to 6250.0 and raises the flag.
`default_nettype none
module four_band_ratio_error_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // band_a_pixel[19:0], band_b_pixel[39:20], band_c_pixel[59:40],
  // band_d_pixel[79:60]
  input  wire  [79:0] s_axis_tdata,
  input  wire         s_axis_tlast,
  // quantity[3:0]
  input  wire  [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // bin_value[47:0], bin_error[95:48]
  output logic [95:0] m_axis_tdata,
  // empty_band[0], value_saturated[1]
  output logic [1:0]  m_axis_tuser
);
  typedef enum logic [5:0] {
    ST_ACC  = 6'b000001,  // taking points
    ST_SETR = 6'b000010,  // load next reciprocal division
    ST_RDIV = 6'b000100,  // reciprocal division bits
    ST_VDIV = 6'b001000,  // value division bits
    ST_SQRT = 6'b010000,  // square root bits
    ST_OUT  = 6'b100000   // result waits for transfer
  } state_t;

  localparam int unsigned DivW = 65;

  state_t state;
  logic [fbre_pkg::SumW-1:0]   sum [4];
  logic [fbre_pkg::CountW-1:0] count;
  logic [fbre_pkg::QtyW-1:0]   qty;
  logic [3:0]  use_mask;    // which reciprocals go into the error
  logic [1:0]  ridx;        // reciprocal being worked
  logic [59:0] rsum;        // sum of reciprocals (4 * 2^56 max)
  // shared restoring divider
  logic [DivW-1:0] dnum;    // dividend shifting out, quotient shifting in
  logic [DivW-1:0] drem;
  logic [DivW-1:0] dden;
  logic [6:0]      dcnt;
  // square root
  logic [43:0] sq_v;        // operand, two bits out per step
  logic [23:0] sq_r;
  logic [23:0] sq_rem;
  logic [4:0]  sq_cnt;
  logic        empty, vsat;
  logic [fbre_pkg::OutW-1:0] value, err;

  logic [1:0] vn_idx, vd_idx;
  logic       is_ratio, is_mean;
  logic [DivW:0]   dtrial;
  logic [DivW:0]   drem_sh;
  logic [25:0]     sq_sh, sq_trial;

  assign is_ratio = (qty >= fbre_pkg::QtyRatioAb) && (qty <= fbre_pkg::QtyRatioDa);
  assign is_mean  = (qty >= fbre_pkg::QtyMeanA) && (qty <= fbre_pkg::QtyMeanD);
  assign vn_idx   = is_ratio ? 2'(qty - fbre_pkg::QtyRatioAb)
                  : is_mean ? 2'(qty - fbre_pkg::QtyMeanA) : 2'd0;
  assign vd_idx   = vn_idx + 2'd1;

  assign drem_sh = {drem, dnum[DivW-1]};
  assign dtrial  = drem_sh - {1'b0, dden};
  assign sq_sh    = {sq_rem, sq_v[43:42]};
  assign sq_trial = sq_sh - {sq_r, 2'b01};

  assign s_axis_tready = (state == ST_ACC);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {err, value};
  assign m_axis_tuser  = {vsat, empty};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      for (int i = 0; i < 4; i++) sum[i] <= '0;
      count <= '0;
    end else begin
      unique case (state)
        ST_ACC: begin
          if (s_axis_tvalid) begin
            logic [fbre_pkg::SumW-1:0] acc [4];
            for (int i = 0; i < 4; i++) acc[i] = sum[i];
            if (count < fbre_pkg::PointCap) begin
              for (int i = 0; i < 4; i++) begin
                logic [fbre_pkg::SumW:0] t;
                t = {1'b0, sum[i]} + (fbre_pkg::SumW+1)'(
                    s_axis_tdata[i*fbre_pkg::PixelW +: fbre_pkg::PixelBits]);
                acc[i] = t[fbre_pkg::SumW] ? fbre_pkg::SumMax : t[fbre_pkg::SumW-1:0];
              end
              count <= count + 1'b1;
            end
            for (int i = 0; i < 4; i++) sum[i] <= acc[i];
            if (s_axis_tlast) begin
              qty   <= s_axis_tuser;
              empty <= (acc[0] == '0) || (acc[1] == '0) || (acc[2] == '0) ||
                       (acc[3] == '0);
              rsum  <= '0;
              ridx  <= '0;
              if ((s_axis_tuser >= fbre_pkg::QtyRatioAb) &&
                  (s_axis_tuser <= fbre_pkg::QtyRatioDa)) begin
                use_mask <= 4'b0011 << 2'(s_axis_tuser - fbre_pkg::QtyRatioAb) |
                            4'b0011 >> 2'(4 - 2'(s_axis_tuser - fbre_pkg::QtyRatioAb));
              end else if ((s_axis_tuser >= fbre_pkg::QtyMeanA) &&
                           (s_axis_tuser <= fbre_pkg::QtyMeanD)) begin
                use_mask <= 4'b0001 << 2'(s_axis_tuser - fbre_pkg::QtyMeanA);
              end else begin
                use_mask <= 4'b1111;
              end
              state <= ST_SETR;
            end
          end
        end
        ST_SETR: begin
          drem <= '0;
          dcnt <= 7'(DivW - 1);
          if (use_mask[ridx] && sum[ridx] != '0) begin
            dnum  <= DivW'(1) << 56;
            dden  <= DivW'(sum[ridx]);
            state <= ST_RDIV;
          end else if (ridx == 2'd3) begin
            // value division next
            if (is_mean) begin
              dnum <= DivW'({sum[vn_idx], 8'd0});
              dden <= DivW'(count);
            end else begin
              dnum <= DivW'({sum[vn_idx], 16'd0});
              dden <= DivW'(sum[vd_idx]);
            end
            state <= ST_VDIV;
          end else begin
            ridx <= ridx + 2'd1;
          end
        end
        ST_RDIV, ST_VDIV: begin
          if (!dtrial[DivW]) begin
            drem <= dtrial[DivW-1:0];
            dnum <= {dnum[DivW-2:0], 1'b1};
          end else begin
            drem <= drem_sh[DivW-1:0];
            dnum <= {dnum[DivW-2:0], 1'b0};
          end
          dcnt <= dcnt - 7'd1;
          if (dcnt == '0) begin
            if (state == ST_RDIV) begin
              rsum <= rsum + 60'({dnum[DivW-2:0], !dtrial[DivW]});
              if (ridx == 2'd3) begin
                ridx <= ridx;
                use_mask <= '0;
              end else begin
                ridx <= ridx + 2'd1;
              end
              state <= ST_SETR;
            end else begin
              logic [DivW-1:0] q;
              q = {dnum[DivW-2:0], !dtrial[DivW]};
              if (dden == '0 || q[DivW-1:fbre_pkg::OutW] != '0) begin
                value <= fbre_pkg::OutMax;
                vsat  <= 1'b1;
              end else begin
                value <= q[fbre_pkg::OutW-1:0];
                vsat  <= 1'b0;
              end
              sq_v   <= rsum[59:16];
              sq_r   <= '0;
              sq_rem <= '0;
              sq_cnt <= 5'd21;
              state  <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (!sq_trial[25]) begin
            sq_rem <= sq_trial[23:0];
            sq_r   <= {sq_r[22:0], 1'b1};
          end else begin
            sq_rem <= sq_sh[23:0];
            sq_r   <= {sq_r[22:0], 1'b0};
          end
          sq_v   <= {sq_v[41:0], 2'b00};
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == '0) begin
            err   <= empty ? fbre_pkg::ErrFlag
                   : fbre_pkg::OutW'({sq_r[22:0], !sq_trial[25]});
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            for (int i = 0; i < 4; i++) sum[i] <= '0;
            count <= '0;
            state <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fbre_checker.sv */
// ----------------------------------------------------------------------------
// fbre_checker
// port-level checks of the four band ratio/error core
// ----------------------------------------------------------------------------
`default_nettype none
module fbre_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [95:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);
  // no point taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("ready while result pending");
  // result held until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed");
  // flagged empty band gives the fixed error
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[95:48] == 48'(64'd100000 << 16))
    else $error("empty error value");
  // after a transfer the core takes points again
  a_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready) else $error("no return");
endmodule

bind four_band_ratio_error_core fbre_checker u_fbre_checker (.*);
`default_nettype wire
